// File: rtl/core/qvb_pkg.sv
// types, constants and coefficient table for the quad vertex batcher
package qvb_pkg;

	localparam int MAX_QUADS     = 8192;
	localparam int TEXTURE_SLOTS = 32;
	localparam int IN_DATA_W     = 248;
	localparam int OUT_DATA_W    = 184;

	localparam logic [15:0] IDX_BUDGET   = 16'(MAX_QUADS * 6);
	localparam logic [15:0] IDX_PER_QUAD = 16'd6;
	localparam logic [5:0]  SLOTS_FULL   = 6'(TEXTURE_SLOTS);
	localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
	localparam logic [30:0] POLY_SEED    = 31'd172272;
	localparam logic [14:0] QUARTER_TURN = 15'd16384;
	localparam logic [63:0] ROUND_HALF   = 64'h0000_0000_4000_0000;

	typedef enum logic [1:0] {
		OP_BEGIN     = 2'd0,
		OP_QUAD_SLOT = 2'd1,
		OP_QUAD_KEY  = 2'd2,
		OP_END       = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_VERTEX = 2'd0,
		KIND_BIND   = 2'd1,
		KIND_DRAW   = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FLUSH_CHK,
		ST_BIND_RD,
		ST_BIND_OUT,
		ST_DRAW,
		ST_FLUSH_END,
		ST_LOOKUP,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_TAKE,
		ST_TRIG,
		ST_SIN_SQ,
		ST_SIN_X2,
		ST_SIN_MUL,
		ST_SIN_SUB,
		ST_SIN_FIN,
		ST_SIN_CLAMP,
		ST_PROD_MUL,
		ST_PROD_ST,
		ST_VERT_SUM,
		ST_VERT_OUT
	} state_t;

	// horner coefficients of the odd sine polynomial, Q1.30
	function automatic logic [30:0] poly_coef(input logic [1:0] k);
		logic [30:0] c;
		case (k)
			2'd0: c = 31'd5026995;
			2'd1: c = 31'd85569306;
			2'd2: c = 31'd693598669;
			default: c = 31'd1686629713;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/quad_vertex_batcher_top.sv
// sprite quad batcher: slot lookup, sine/cosine, corner rotation, flush sequencing
// a quad with a given slot goes from accept through sine, cosine, products and four vertices;
// a quad by texture id first searches the table, a flush sends a bind per used slot and a draw
// throughput: one item at a time, set by the single shared 33x33 multiplier (16 products per quad)
// and by the one-port slot table read for search and binds
// reset: counters cleared, one slot in use, white texture id zero, output empty;
// slot table contents are not cleared
module quad_vertex_batcher_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z, size_x, size_y, angle, rgba, slot_in, texture_key, tiling, pad
	input  logic [247:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// vert_x, vert_y, vert_z, vert_color, corner_u, corner_v, slot_out, vert_tiling,
	// bound_texture, index_total, pad
	output logic [183:0] m_tdata,
	// kind
	output logic [1:0]   m_tuser,
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	qvb_pkg::state_t  state_q, state_d, ret_q;
	qvb_pkg::opcode_t op_q, s_op;
	logic             restart_q;
	logic             accept, cfg_wr, out_free, out_load;

	logic [31:0] pos_x_q, pos_y_q, pos_z_q, size_x_q, size_y_q, rgba_q;
	logic [15:0] angle_q, key_q, tiling_q;
	logic [4:0]  slot_in_q, slot_q;

	logic [15:0] idx_q, white_q, rd_q;
	logic [5:0]  su_q, ptr_q;
	logic [15:0] slot_mem [32];

	logic [30:0] x_q, x2_q, t_q, sf_q, cf_q, sm, cm, clamp_v;
	logic [1:0]  k_q, pk_q, cn_q;
	logic        phase_q, sneg, cneg, gxp, gyp;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [63:0]        mul_q;
	logic [63:0]        p_q [4];
	logic [63:0]        sumx_q, sumy_q, sumx_d, sumy_d;

	logic [183:0] o_data;
	logic [1:0]   o_kind;
	logic         o_last;
	logic [31:0]  vx, vy;
	logic [15:0]  o_bound;

	logic         m_tvalid_q, m_tlast_q;
	logic [183:0] m_tdata_q;
	logic [1:0]   m_tuser_q;

	assign s_tready = (state_q == qvb_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign s_op     = qvb_pkg::opcode_t'(s_tuser);
	assign out_free = !m_tvalid_q || m_tready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, white_q};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// quadrant folding of sine and cosine
	assign sm      = angle_q[14] ? cf_q : sf_q;
	assign cm      = angle_q[14] ? sf_q : cf_q;
	assign sneg    = angle_q[15];
	assign cneg    = angle_q[15] ^ angle_q[14];
	assign gxp     = cn_q[0] ^ cn_q[1];
	assign gyp     = cn_q[1];
	assign clamp_v = (mul_q[60:30] > qvb_pkg::ONE_Q30) ? qvb_pkg::ONE_Q30 : mul_q[60:30];

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			qvb_pkg::ST_SIN_SQ: begin
				mul_a = {2'b00, x_q};
				mul_b = {2'b00, x_q};
			end
			qvb_pkg::ST_SIN_MUL: begin
				mul_a = {2'b00, t_q};
				mul_b = {2'b00, x2_q};
			end
			qvb_pkg::ST_SIN_FIN: begin
				mul_a = {2'b00, t_q};
				mul_b = {2'b00, x_q};
			end
			qvb_pkg::ST_PROD_MUL: begin
				case (pk_q)
					2'd0: begin
						mul_a = {size_x_q[31], size_x_q};
						mul_b = {2'b00, cm};
					end
					2'd1: begin
						mul_a = {size_y_q[31], size_y_q};
						mul_b = {2'b00, sm};
					end
					2'd2: begin
						mul_a = {size_x_q[31], size_x_q};
						mul_b = {2'b00, sm};
					end
					default: begin
						mul_a = {size_y_q[31], size_y_q};
						mul_b = {2'b00, cm};
					end
				endcase
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// corner offsets before the round shift
	always_comb begin
		sumx_d = (gxp ^ cneg ? p_q[0] : -p_q[0])
			+ (gyp ^ sneg ? -p_q[1] : p_q[1]) + qvb_pkg::ROUND_HALF;
		sumy_d = (gxp ^ sneg ? p_q[2] : -p_q[2])
			+ (gyp ^ cneg ? p_q[3] : -p_q[3]) + qvb_pkg::ROUND_HALF;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			qvb_pkg::ST_IDLE: begin
				if (accept) begin
					case (s_op)
						qvb_pkg::OP_BEGIN: state_d = qvb_pkg::ST_IDLE;
						qvb_pkg::OP_END:   state_d = qvb_pkg::ST_FLUSH_CHK;
						default: state_d = (idx_q >= qvb_pkg::IDX_BUDGET)
							? qvb_pkg::ST_FLUSH_CHK : qvb_pkg::ST_LOOKUP;
					endcase
				end
			end
			qvb_pkg::ST_FLUSH_CHK: state_d = (idx_q == 16'd0)
				? qvb_pkg::ST_FLUSH_END : qvb_pkg::ST_BIND_RD;
			qvb_pkg::ST_BIND_RD: state_d = qvb_pkg::ST_BIND_OUT;
			qvb_pkg::ST_BIND_OUT: begin
				if (out_free)
					state_d = (ptr_q + 6'd1 >= su_q) ? qvb_pkg::ST_DRAW : qvb_pkg::ST_BIND_RD;
			end
			qvb_pkg::ST_DRAW: begin
				if (out_free)
					state_d = qvb_pkg::ST_FLUSH_END;
			end
			qvb_pkg::ST_FLUSH_END: state_d = ret_q;
			qvb_pkg::ST_LOOKUP: state_d = (op_q == qvb_pkg::OP_QUAD_SLOT)
				? qvb_pkg::ST_TRIG : qvb_pkg::ST_SRCH_RD;
			qvb_pkg::ST_SRCH_RD: begin
				if (ptr_q >= su_q)
					state_d = (su_q >= qvb_pkg::SLOTS_FULL)
						? qvb_pkg::ST_FLUSH_CHK : qvb_pkg::ST_TAKE;
				else
					state_d = qvb_pkg::ST_SRCH_CMP;
			end
			qvb_pkg::ST_SRCH_CMP: state_d = (rd_q == key_q)
				? qvb_pkg::ST_TRIG : qvb_pkg::ST_SRCH_RD;
			qvb_pkg::ST_TAKE:   state_d = qvb_pkg::ST_TRIG;
			qvb_pkg::ST_TRIG:   state_d = qvb_pkg::ST_SIN_SQ;
			qvb_pkg::ST_SIN_SQ: state_d = qvb_pkg::ST_SIN_X2;
			qvb_pkg::ST_SIN_X2: state_d = qvb_pkg::ST_SIN_MUL;
			qvb_pkg::ST_SIN_MUL: state_d = qvb_pkg::ST_SIN_SUB;
			qvb_pkg::ST_SIN_SUB: state_d = (k_q == 2'd3)
				? qvb_pkg::ST_SIN_FIN : qvb_pkg::ST_SIN_MUL;
			qvb_pkg::ST_SIN_FIN: state_d = qvb_pkg::ST_SIN_CLAMP;
			qvb_pkg::ST_SIN_CLAMP: state_d = phase_q
				? qvb_pkg::ST_PROD_MUL : qvb_pkg::ST_SIN_SQ;
			qvb_pkg::ST_PROD_MUL: state_d = qvb_pkg::ST_PROD_ST;
			qvb_pkg::ST_PROD_ST: state_d = (pk_q == 2'd3)
				? qvb_pkg::ST_VERT_SUM : qvb_pkg::ST_PROD_MUL;
			qvb_pkg::ST_VERT_SUM: state_d = qvb_pkg::ST_VERT_OUT;
			qvb_pkg::ST_VERT_OUT: begin
				if (out_free)
					state_d = (cn_q == 2'd3) ? qvb_pkg::ST_IDLE : qvb_pkg::ST_VERT_SUM;
			end
			default: state_d = qvb_pkg::ST_IDLE;
		endcase
	end

	// result composition
	always_comb begin
		out_load = 1'b0;
		o_kind   = qvb_pkg::KIND_VERTEX;
		o_last   = 1'b0;
		o_data   = '0;
		vx       = pos_x_q + sumx_q[62:31];
		vy       = pos_y_q + sumy_q[62:31];
		o_bound  = (ptr_q == 6'd0) ? white_q : rd_q;
		case (state_q)
			qvb_pkg::ST_BIND_OUT: begin
				out_load        = out_free;
				o_kind          = qvb_pkg::KIND_BIND;
				o_data[134:130] = ptr_q[4:0];
				o_data[166:151] = o_bound;
			end
			qvb_pkg::ST_DRAW: begin
				out_load        = out_free;
				o_kind          = qvb_pkg::KIND_DRAW;
				o_last          = (ret_q == qvb_pkg::ST_IDLE);
				o_data[182:167] = idx_q;
			end
			qvb_pkg::ST_VERT_OUT: begin
				out_load        = out_free;
				o_kind          = qvb_pkg::KIND_VERTEX;
				o_last          = (cn_q == 2'd3);
				o_data[31:0]    = vx;
				o_data[63:32]   = vy;
				o_data[95:64]   = pos_z_q;
				o_data[127:96]  = rgba_q;
				o_data[128]     = gxp;
				o_data[129]     = gyp;
				o_data[134:130] = slot_q;
				o_data[150:135] = tiling_q;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= qvb_pkg::ST_IDLE;
			ret_q      <= qvb_pkg::ST_IDLE;
			restart_q  <= 1'b0;
			idx_q      <= '0;
			su_q       <= 6'd1;
			ptr_q      <= '0;
			k_q        <= '0;
			pk_q       <= '0;
			cn_q       <= '0;
			phase_q    <= 1'b0;
			white_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && !paddr[2])
				white_q <= pwdata[15:0];
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				qvb_pkg::ST_IDLE: begin
					if (accept) begin
						case (s_op)
							qvb_pkg::OP_BEGIN: begin
								idx_q <= '0;
								su_q  <= 6'd1;
							end
							qvb_pkg::OP_END: begin
								ret_q     <= qvb_pkg::ST_IDLE;
								restart_q <= 1'b0;
							end
							default: begin
								ret_q     <= qvb_pkg::ST_LOOKUP;
								restart_q <= 1'b1;
							end
						endcase
					end
				end
				qvb_pkg::ST_FLUSH_CHK: ptr_q <= '0;
				qvb_pkg::ST_BIND_OUT: begin
					if (out_free)
						ptr_q <= ptr_q + 6'd1;
				end
				qvb_pkg::ST_FLUSH_END: begin
					if (restart_q) begin
						idx_q <= '0;
						su_q  <= 6'd1;
					end
				end
				qvb_pkg::ST_LOOKUP: ptr_q <= 6'd1;
				qvb_pkg::ST_SRCH_RD: begin
					if (ptr_q >= su_q && su_q >= qvb_pkg::SLOTS_FULL) begin
						ret_q     <= qvb_pkg::ST_TAKE;
						restart_q <= 1'b1;
					end
				end
				qvb_pkg::ST_SRCH_CMP: begin
					if (rd_q != key_q)
						ptr_q <= ptr_q + 6'd1;
				end
				qvb_pkg::ST_TAKE: su_q <= su_q + 6'd1;
				qvb_pkg::ST_TRIG: phase_q <= 1'b0;
				qvb_pkg::ST_SIN_X2: k_q <= '0;
				qvb_pkg::ST_SIN_SUB: k_q <= k_q + 2'd1;
				qvb_pkg::ST_SIN_CLAMP: begin
					phase_q <= 1'b1;
					pk_q    <= '0;
				end
				qvb_pkg::ST_PROD_ST: begin
					pk_q <= pk_q + 2'd1;
					cn_q <= '0;
				end
				qvb_pkg::ST_VERT_OUT: begin
					if (out_free) begin
						cn_q <= cn_q + 2'd1;
						if (cn_q == 2'd3)
							idx_q <= idx_q + qvb_pkg::IDX_PER_QUAD;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mul_q <= mul_p[63:0];
		if (accept) begin
			op_q      <= s_op;
			pos_x_q   <= s_tdata[31:0];
			pos_y_q   <= s_tdata[63:32];
			pos_z_q   <= s_tdata[95:64];
			size_x_q  <= s_tdata[127:96];
			size_y_q  <= s_tdata[159:128];
			angle_q   <= s_tdata[175:160];
			rgba_q    <= s_tdata[207:176];
			slot_in_q <= s_tdata[212:208];
			key_q     <= s_tdata[228:213];
			tiling_q  <= s_tdata[244:229];
		end
		case (state_q)
			qvb_pkg::ST_LOOKUP: slot_q <= slot_in_q;
			qvb_pkg::ST_SRCH_CMP: slot_q <= ptr_q[4:0];
			qvb_pkg::ST_TAKE: slot_q <= su_q[4:0];
			qvb_pkg::ST_TRIG: x_q <= {1'b0, angle_q[13:0], 16'd0};
			qvb_pkg::ST_SIN_X2: begin
				x2_q <= mul_q[60:30];
				t_q  <= qvb_pkg::POLY_SEED;
			end
			qvb_pkg::ST_SIN_SUB: t_q <= qvb_pkg::poly_coef(k_q) - mul_q[60:30];
			qvb_pkg::ST_SIN_CLAMP: begin
				if (phase_q) begin
					cf_q <= clamp_v;
				end else begin
					sf_q <= clamp_v;
					x_q  <= {qvb_pkg::QUARTER_TURN - {1'b0, angle_q[13:0]}, 16'd0};
				end
			end
			qvb_pkg::ST_PROD_ST: p_q[pk_q] <= mul_q;
			qvb_pkg::ST_VERT_SUM: begin
				sumx_q <= sumx_d;
				sumy_q <= sumy_d;
			end
			default: ;
		endcase
		if (out_load) begin
			m_tdata_q <= o_data;
			m_tuser_q <= o_kind;
			m_tlast_q <= o_last;
		end
	end

	// slot table
	always_ff @(posedge clk) begin
		if (state_q == qvb_pkg::ST_TAKE)
			slot_mem[su_q[4:0]] <= key_q;
		rd_q <= slot_mem[ptr_q[4:0]];
	end

`ifndef SYNTHESIS
	a_slots_range: assert property (@(posedge clk) disable iff (!arst_n)
		su_q >= 6'd1 && su_q <= qvb_pkg::SLOTS_FULL)
		else $error("slot count out of range");

	a_idx_budget: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= qvb_pkg::IDX_BUDGET)
		else $error("index counter beyond budget");

	a_bind_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == qvb_pkg::ST_BIND_RD |-> ptr_q < su_q)
		else $error("bind beyond used slots");

	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == qvb_pkg::ST_TAKE |-> su_q < qvb_pkg::SLOTS_FULL)
		else $error("slot taken from full table");

	a_quad_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == qvb_pkg::ST_VERT_OUT && out_free && cn_q == 2'd3
		|=> state_q == qvb_pkg::ST_IDLE && idx_q == $past(idx_q) + qvb_pkg::IDX_PER_QUAD)
		else $error("quad did not close cleanly");
`endif

endmodule

// File: tb/quad_vertex_batcher_checker.sv
`timescale 1ns / 100ps
// checker for the quad vertex batcher: predicts vertices, binds and draws and compares them
module quad_vertex_batcher_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [247:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [183:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           mismatch_count,
	output int           results_pending
);

	localparam logic [2:0] WHITE_ID_ADDR = 3'd0;

	typedef struct packed {
		logic [2:0]  pad;
		logic [15:0] tiling;
		logic [15:0] texture_key;
		logic [4:0]  slot_in;
		logic [31:0] rgba;
		logic [15:0] angle;
		logic [31:0] size_y;
		logic [31:0] size_x;
		logic [31:0] pos_z;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
	} quad_request_t;

	typedef struct packed {
		logic        pad;
		logic [15:0] index_total;
		logic [15:0] bound_texture;
		logic [15:0] vert_tiling;
		logic [4:0]  slot_out;
		logic        corner_v;
		logic        corner_u;
		logic [31:0] vert_color;
		logic [31:0] vert_z;
		logic [31:0] vert_y;
		logic [31:0] vert_x;
	} batch_word_t;

	typedef struct packed {
		qvb_pkg::kind_t kind;
		logic           last;
		batch_word_t    word;
	} batch_out_t;

	logic [15:0] white_id;
	logic [15:0] slot_ids [32];
	int unsigned idx_count;
	int unsigned slots_in_use;
	int          fail_total;
	batch_out_t  batch_outputs_q [$];
	batch_out_t  got;
	batch_out_t  want;
	string       diff;

	// sin(pi/2 * n / 16384) in Q2.30
	function automatic logic [63:0] sine_q30(input logic [14:0] n);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x = 64'(n) << 16;
		x2 = (x * x) >> 30;
		t = 64'd172272;
		t = 64'd5026995 - ((t * x2) >> 30);
		t = 64'd85569306 - ((t * x2) >> 30);
		t = 64'd693598669 - ((t * x2) >> 30);
		t = 64'd1686629713 - ((t * x2) >> 30);
		t = (t * x) >> 30;
		return (t > 64'd1073741824) ? 64'd1073741824 : t;
	endfunction

	task automatic flush_batch();
		batch_out_t  row;
		int unsigned i;
		if (idx_count != 0) begin
			for (i = 0; i < slots_in_use; i++) begin
				row = '0;
				row.kind = qvb_pkg::KIND_BIND;
				row.word.slot_out = 5'(i);
				row.word.bound_texture = (i == 0) ? white_id : slot_ids[i];
				batch_outputs_q.push_back(row);
			end
			row = '0;
			row.kind = qvb_pkg::KIND_DRAW;
			row.word.index_total = 16'(idx_count);
			batch_outputs_q.push_back(row);
		end
	endtask

	task automatic restart_batch();
		flush_batch();
		idx_count = 0;
		slots_in_use = 1;
	endtask

	task automatic emit_vertices(input quad_request_t r, input logic [4:0] slot);
		longint     sf;
		longint     cf;
		longint     s;
		longint     c;
		longint     sx;
		longint     sy;
		longint     hx;
		longint     hy;
		longint     ox;
		longint     oy;
		int         k;
		batch_out_t row;
		sf = longint'(sine_q30({1'b0, r.angle[13:0]}));
		cf = longint'(sine_q30(15'd16384 - {1'b0, r.angle[13:0]}));
		case (r.angle[15:14])
			2'd0: begin
				s = sf;
				c = cf;
			end
			2'd1: begin
				s = cf;
				c = -sf;
			end
			2'd2: begin
				s = -sf;
				c = -cf;
			end
			default: begin
				s = -cf;
				c = sf;
			end
		endcase
		sx = longint'($signed(r.size_x));
		sy = longint'($signed(r.size_y));
		// corners (-,-) (+,-) (+,+) (-,+)
		for (k = 0; k < 4; k++) begin
			hx = (k == 1 || k == 2) ? sx : -sx;
			hy = (k >= 2) ? sy : -sy;
			ox = (hx * c - hy * s + 64'sd1073741824) >>> 31;
			oy = (hx * s + hy * c + 64'sd1073741824) >>> 31;
			row = '0;
			row.kind = qvb_pkg::KIND_VERTEX;
			row.word.vert_x = r.pos_x + ox[31:0];
			row.word.vert_y = r.pos_y + oy[31:0];
			row.word.vert_z = r.pos_z;
			row.word.vert_color = r.rgba;
			row.word.corner_u = (k == 1 || k == 2);
			row.word.corner_v = (k >= 2);
			row.word.slot_out = slot;
			row.word.vert_tiling = r.tiling;
			batch_outputs_q.push_back(row);
		end
		idx_count += 6;
	endtask

	task automatic model_command(input qvb_pkg::opcode_t op, input quad_request_t r);
		int          queued_count;
		int unsigned i;
		logic [4:0]  slot;
		batch_out_t  tail;
		queued_count = batch_outputs_q.size();
		case (op)
			qvb_pkg::OP_BEGIN: begin
				idx_count = 0;
				slots_in_use = 1;
			end
			qvb_pkg::OP_END: flush_batch();
			default: begin
				if (idx_count >= qvb_pkg::MAX_QUADS * 6)
					restart_batch();
				if (op == qvb_pkg::OP_QUAD_SLOT) begin
					slot = r.slot_in;
				end else begin
					slot = '0;
					for (i = 1; i < slots_in_use; i++) begin
						if (slot_ids[i] == r.texture_key) begin
							slot = 5'(i);
							break;
						end
					end
					if (slot == 0) begin
						if (slots_in_use >= qvb_pkg::TEXTURE_SLOTS)
							restart_batch();
						slot = 5'(slots_in_use);
						slot_ids[slots_in_use] = r.texture_key;
						slots_in_use++;
					end
				end
				emit_vertices(r, slot);
			end
		endcase
		if (batch_outputs_q.size() > queued_count) begin
			tail = batch_outputs_q.pop_back();
			tail.last = 1'b1;
			batch_outputs_q.push_back(tail);
		end
	endtask

	function automatic string field_diffs(input batch_out_t w, input batch_out_t g);
		string s;
		s = "";
		if (w.kind != g.kind) s = {s, " kind"};
		if (w.last != g.last) s = {s, " last"};
		if (w.word.vert_x != g.word.vert_x) s = {s, " vert_x"};
		if (w.word.vert_y != g.word.vert_y) s = {s, " vert_y"};
		if (w.word.vert_z != g.word.vert_z) s = {s, " vert_z"};
		if (w.word.vert_color != g.word.vert_color) s = {s, " vert_color"};
		if (w.word.corner_u != g.word.corner_u) s = {s, " corner_u"};
		if (w.word.corner_v != g.word.corner_v) s = {s, " corner_v"};
		if (w.word.slot_out != g.word.slot_out) s = {s, " slot_out"};
		if (w.word.vert_tiling != g.word.vert_tiling) s = {s, " vert_tiling"};
		if (w.word.bound_texture != g.word.bound_texture) s = {s, " bound_texture"};
		if (w.word.index_total != g.word.index_total) s = {s, " index_total"};
		if (w.word.pad != g.word.pad) s = {s, " pad"};
		return s;
	endfunction

	function automatic string fmt_result(input batch_out_t b);
		return $sformatf({"kind=%0d last=%0b x=%h y=%h z=%h rgba=%h uv=%0b%0b",
			" slot=%0d til=%h tex=%h idx=%0d"},
			b.kind, b.last, b.word.vert_x, b.word.vert_y, b.word.vert_z, b.word.vert_color,
			b.word.corner_u, b.word.corner_v, b.word.slot_out, b.word.vert_tiling,
			b.word.bound_texture, b.word.index_total);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_id = '0;
			idx_count = 0;
			slots_in_use = 1;
			fail_total = 0;
			foreach (slot_ids[i])
				slot_ids[i] = '0;
			batch_outputs_q.delete();
			mismatch_count <= 0;
			results_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == WHITE_ID_ADDR)
				white_id = pwdata[15:0];
			if (s_tvalid && s_tready)
				model_command(qvb_pkg::opcode_t'(s_tuser), quad_request_t'(s_tdata));
			if (m_tvalid && m_tready) begin
				got.kind = qvb_pkg::kind_t'(m_tuser);
				got.last = m_tlast;
				got.word = batch_word_t'(m_tdata);
				if (batch_outputs_q.size() == 0) begin
					if (fail_total < 10)
						$display("%0t: result with nothing pending: %s", $time, fmt_result(got));
					fail_total++;
				end else begin
					want = batch_outputs_q.pop_front();
					diff = field_diffs(want, got);
					if (diff != "") begin
						if (fail_total < 10) begin
							$display("%0t: mismatch in%s", $time, diff);
							$display("  expected %s", fmt_result(want));
							$display("  actual   %s", fmt_result(got));
						end
						fail_total++;
					end
				end
			end
			mismatch_count <= fail_total;
			results_pending <= batch_outputs_q.size();
		end
	end

endmodule

// File: tb/quad_vertex_batcher_top_test.sv
`timescale 1ns / 100ps
// top of the quad vertex batcher testbench: clock, reset, request stimulus and verdict
module quad_vertex_batcher_top_test;

	localparam logic [2:0]  REG_WHITE_ID  = 3'd0;
	localparam int          SETTLE_CYCLES = 200;
	localparam int unsigned CYCLE_LIMIT   = 2000000;
	localparam logic [31:0] P_MAX         = 32'h7FFF_FFFF;
	localparam logic [31:0] P_MIN         = 32'h8000_0000;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [247:0] s_tdata  = '0;
	logic [1:0]   s_tuser  = qvb_pkg::OP_BEGIN;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [183:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [2:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;

	int          mismatch_count;
	int          results_pending;
	int          send_idle_pct = 24;
	int          recv_idle_pct = 60;
	int unsigned cycle_count   = 0;
	logic [15:0] white_id      = '0;

	quad_vertex_batcher_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	quad_vertex_batcher_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.mismatch_count(mismatch_count), .results_pending(results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [247:0] pack_request(
		input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
		input logic [31:0] sx, input logic [31:0] sy, input logic [15:0] ang,
		input logic [31:0] rgba, input logic [4:0] slot, input logic [15:0] key,
		input logic [15:0] tiling);
		return {3'b000, tiling, key, slot, rgba, ang, sy, sx, pz, py, px};
	endfunction

	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
			2: v = $urandom_range(32'h07FF_FFFF) - 32'h0400_0000;
			default: v = ($urandom_range(1) != 0) ? P_MAX : P_MIN;
		endcase
		return v;
	endfunction

	function automatic logic [247:0] random_request(input logic [15:0] key);
		return pack_request(rand_coord(), rand_coord(), $urandom, rand_coord(), rand_coord(),
			16'($urandom), $urandom, 5'($urandom), key, 16'($urandom));
	endfunction

	task automatic send_request(input qvb_pkg::opcode_t op, input logic [247:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
	endtask

	task automatic write_white_id(input logic [15:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= REG_WHITE_ID;
		pwdata <= {16'h0000, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		white_id = v;
	endtask

	task automatic change_white_id(input logic [15:0] v);
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_white_id(v);
	endtask

	task automatic run_batches(input int target);
		int               sent;
		int               n;
		int               i;
		int               pick;
		logic [15:0]      base;
		logic [15:0]      key_pool [6];
		qvb_pkg::opcode_t op;
		key_pool[0] = white_id;
		key_pool[1] = 16'h0000;
		key_pool[2] = 16'hFFFF;
		for (i = 3; i < 6; i++)
			key_pool[i] = 16'($urandom);
		// distinct ids that overflow the slot table
		base = 16'($urandom);
		n = $urandom_range(33, 36);
		send_request(qvb_pkg::OP_BEGIN, random_request(16'($urandom)));
		for (i = 0; i < n; i++)
			send_request(qvb_pkg::OP_QUAD_KEY, random_request(base + 16'(i)));
		send_request(qvb_pkg::OP_END, random_request(16'($urandom)));
		sent = n + 2;
		while (sent < target) begin
			pick = $urandom_range(9);
			if (pick < 8) begin
				n = $urandom_range(1, 10);
				if (pick != 7) begin
					send_request(qvb_pkg::OP_BEGIN, random_request(16'($urandom)));
					sent++;
				end
				for (i = 0; i < n; i++) begin
					op = ($urandom_range(1) != 0) ? qvb_pkg::OP_QUAD_SLOT : qvb_pkg::OP_QUAD_KEY;
					send_request(op, random_request(key_pool[$urandom_range(5)]));
				end
				sent += n;
				if (pick != 6) begin
					send_request(qvb_pkg::OP_END, random_request(16'($urandom)));
					sent++;
				end
			end else begin
				op = qvb_pkg::opcode_t'($urandom_range(3));
				send_request(op, random_request(16'($urandom)));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_white_id(16'h0000);

		send_request(qvb_pkg::OP_END, random_request(16'($urandom)));
		send_request(qvb_pkg::OP_BEGIN, random_request(16'($urandom)));
		send_request(qvb_pkg::OP_QUAD_SLOT, pack_request('0, '0, '0, '0, '0, 16'h0000, '0,
			5'd0, 16'h0000, 16'h0000));
		send_request(qvb_pkg::OP_QUAD_SLOT, pack_request(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX,
			16'h4000, 32'hFFFF_FFFF, 5'd31, 16'hFFFF, 16'hFFFF));
		send_request(qvb_pkg::OP_QUAD_SLOT, pack_request(P_MIN, P_MIN, P_MIN, P_MIN, P_MIN,
			16'h8000, 32'h0000_0000, 5'd17, 16'h0000, 16'h0100));
		send_request(qvb_pkg::OP_QUAD_SLOT, pack_request(P_MAX, P_MIN, '0, P_MIN, P_MAX,
			16'hC000, 32'h8040_2010, 5'd1, 16'h5555, 16'h8000));
		send_request(qvb_pkg::OP_QUAD_SLOT, pack_request(32'h0001_0000, 32'hFFFF_0000, 32'h0,
			32'h0002_0000, 32'h0001_0000, 16'h2000, 32'h1234_5678, 5'd2, 16'h0, 16'h0080));
		send_request(qvb_pkg::OP_QUAD_SLOT, pack_request(rand_coord(), rand_coord(), $urandom,
			rand_coord(), rand_coord(), 16'hFFFF, $urandom, 5'd9, 16'h0, 16'h0001));
		send_request(qvb_pkg::OP_QUAD_SLOT, pack_request(rand_coord(), rand_coord(), $urandom,
			P_MAX, P_MIN, 16'h3FFF, $urandom, 5'd30, 16'h0, 16'h7FFF));
		send_request(qvb_pkg::OP_QUAD_KEY, random_request(16'h0000));
		send_request(qvb_pkg::OP_QUAD_KEY, random_request(16'hFFFF));
		send_request(qvb_pkg::OP_QUAD_KEY, random_request(16'h0000));
		send_request(qvb_pkg::OP_QUAD_KEY, random_request(16'hFFFF));
		send_request(qvb_pkg::OP_END, random_request(16'($urandom)));
		send_request(qvb_pkg::OP_END, random_request(16'($urandom)));
		send_request(qvb_pkg::OP_QUAD_KEY, random_request(16'h1234));
		send_request(qvb_pkg::OP_BEGIN, random_request(16'($urandom)));
		send_request(qvb_pkg::OP_QUAD_KEY, random_request(16'h1234));
		send_request(qvb_pkg::OP_BEGIN, random_request(16'($urandom)));
		send_request(qvb_pkg::OP_END, random_request(16'($urandom)));
		send_request(qvb_pkg::OP_QUAD_SLOT, random_request(16'($urandom)));
		send_request(qvb_pkg::OP_END, random_request(16'($urandom)));

		change_white_id(16'hFFFF);
		send_idle_pct = 24;
		recv_idle_pct = 60;
		run_batches(45);
		wait_results_drained();
		run_batches(45);

		change_white_id(16'($urandom));
		send_idle_pct = 60;
		recv_idle_pct = 24;
		run_batches(95);

		change_white_id(16'h8001);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_batches(60);

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
